// ----- rtl/hwm_pkg.sv -----
package hwm_pkg;

  // Field widths of the request and result channels.
  localparam int HOUR_W = 32;
  localparam int BYTE_W = 64;
  localparam int WIN_W  = 5;
  localparam int KEPT_W = 5;
  localparam int MODE_W = 2;

  // Request mode codes; the fourth code is unused and ignored.
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DETAIL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOTAL  = 2'd2;

  // One hourly bucket as held in a cell of the chain.
  typedef struct packed {
    logic              valid;
    logic [HOUR_W-1:0] hour;
    logic [BYTE_W-1:0] recv;
    logic [BYTE_W-1:0] sent;
  } bucket_t;

  // Operation applied to the chain.
  typedef enum logic [2:0] {
    CH_HOLD,
    CH_PUSH,
    CH_LOAD_HEAD,
    CH_ROTATE,
    CH_SQUEEZE
  } chain_op_t;

  // What a single cell loads.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LO,
    CELL_FROM_HI,
    CELL_SQUEEZE
  } cell_cmd_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_SQUEEZE,
    ST_ADD,
    ST_DETAIL,
    ST_RESTORE,
    ST_TOTAL
  } state_t;

endpackage

// ----- rtl/hourly_traffic_window_meter.sv -----
// Hourly traffic meter: keeps up to MAX_HOURS hourly buckets of received and
// sent bytes in a chain of cells, newest at the head, and reports them over a
// window of cfg window_hours (clamped to 1..MAX_HOURS). An add request for the
// hour already at the head goes straight to the add step. An add that opens a
// new hour first pushes a new bucket, then makes one rotation of the whole
// chain past the head to purge and re-total, then squeezes to close the gaps.
// A detail request gives one result a cycle for the window while the result
// side does not stall, and then rotates the chain back to its home position.
// A total request gives one result. Adds with both counts zero and requests
// of the unused mode are dropped.
module hourly_traffic_window_meter #(
  parameter int MAX_HOURS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [hwm_pkg::WIN_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hwm_pkg::MODE_W-1:0]  in_mode,
  input  logic [hwm_pkg::HOUR_W-1:0]  in_hour,
  input  logic [hwm_pkg::BYTE_W-1:0]  in_recv_bytes,
  input  logic [hwm_pkg::BYTE_W-1:0]  in_sent_bytes,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hwm_pkg::BYTE_W-1:0]  out_hour_recv,
  output logic [hwm_pkg::BYTE_W-1:0]  out_hour_sent,
  output logic [hwm_pkg::BYTE_W-1:0]  out_window_total,
  output logic [hwm_pkg::KEPT_W-1:0]  out_kept_hours,
  output logic                        out_last
);
  import hwm_pkg::*;

  localparam int CW    = $clog2(MAX_HOURS + 1);
  localparam int WCMP_W = (CW > WIN_W) ? CW : WIN_W;
  localparam int HX_W  = HOUR_W + 1;

  state_t            state_r, state_nxt;
  logic [WIN_W-1:0]  win_r;
  logic [CW-1:0]     w_eff;
  logic [WCMP_W-1:0] win_ext;

  logic [CW-1:0]     step_r, step_nxt;
  logic [CW-1:0]     rot_r, rot_nxt;
  logic [CW-1:0]     kept_r, kept_nxt;
  logic [BYTE_W-1:0] tot_recv_r, tot_recv_nxt;
  logic [BYTE_W-1:0] tot_sent_r, tot_sent_nxt;
  logic [HOUR_W-1:0] hour_r, hour_nxt;
  logic              neg_r, neg_nxt;
  logic [BYTE_W-1:0] rb_r, rb_nxt;
  logic [BYTE_W-1:0] sb_r, sb_nxt;

  chain_op_t chain_op;
  bucket_t   push_bucket;
  bucket_t   wrap_bucket;
  bucket_t   head;
  logic      keep;
  logic      match;
  logic      out_free;

  logic              out_valid_r;
  logic              out_load;
  logic [BYTE_W-1:0] ld_recv, ld_sent, ld_total;
  logic [KEPT_W-1:0] ld_kept;
  logic              ld_last;
  logic [BYTE_W-1:0] out_recv_r, out_sent_r, out_total_r;
  logic [KEPT_W-1:0] out_kept_r;
  logic              out_last_r;

  // Window register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= WIN_W'(24);
    end else if (cfg_wr_en) begin
      win_r <= cfg_wr_data;
    end
  end

  // Window in use, clamped to 1..MAX_HOURS.
  assign win_ext = WCMP_W'(win_r);
  always_comb begin
    if (win_r == '0) begin
      w_eff = CW'(1);
    end else if (win_ext > WCMP_W'(MAX_HOURS)) begin
      w_eff = CW'(MAX_HOURS);
    end else begin
      w_eff = CW'(win_ext);
    end
  end

  hwm_chain #(
    .MAX_HOURS (MAX_HOURS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (chain_op),
    .push_in (push_bucket),
    .wrap_in (wrap_bucket),
    .head    (head)
  );

  // A bucket survives the purge when its hour lies in (hour - window, hour].
  assign keep = head.valid && (head.hour <= hour_r) &&
                (({1'b0, head.hour} + HX_W'(w_eff)) > {1'b0, hour_r});

  // The detail walk advances when the head bucket holds the reported hour.
  assign match    = head.valid && !neg_r && (head.hour == hour_r);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Sequencer: next state, chain operation and result loading.
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    rot_nxt      = rot_r;
    kept_nxt     = kept_r;
    tot_recv_nxt = tot_recv_r;
    tot_sent_nxt = tot_sent_r;
    hour_nxt     = hour_r;
    neg_nxt      = neg_r;
    rb_nxt       = rb_r;
    sb_nxt       = sb_r;
    chain_op     = CH_HOLD;
    push_bucket  = '0;
    wrap_bucket  = head;
    out_load     = 1'b0;
    ld_recv      = '0;
    ld_sent      = '0;
    ld_total     = '0;
    ld_kept      = '0;
    ld_last      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          hour_nxt = in_hour;
          rb_nxt   = in_recv_bytes;
          sb_nxt   = in_sent_bytes;
          neg_nxt  = 1'b0;
          step_nxt = '0;
          rot_nxt  = '0;
          case (in_mode)
            MODE_ADD: begin
              if (in_recv_bytes != '0 || in_sent_bytes != '0) begin
                if (!head.valid || head.hour != in_hour) begin
                  // Open a new newest bucket and start the purge.
                  chain_op         = CH_PUSH;
                  push_bucket.valid = 1'b1;
                  push_bucket.hour  = in_hour;
                  kept_nxt         = '0;
                  tot_recv_nxt     = '0;
                  tot_sent_nxt     = '0;
                  state_nxt        = ST_MARK;
                end else begin
                  state_nxt = ST_ADD;
                end
              end
            end
            MODE_DETAIL: state_nxt = ST_DETAIL;
            MODE_TOTAL:  state_nxt = ST_TOTAL;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_MARK: begin
        // Rotate once round the chain, marking and totalling survivors.
        chain_op          = CH_ROTATE;
        wrap_bucket.valid = keep;
        if (keep) begin
          tot_recv_nxt = tot_recv_r + head.recv;
          tot_sent_nxt = tot_sent_r + head.sent;
          kept_nxt     = kept_r + CW'(1);
        end
        if (step_r == CW'(MAX_HOURS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_SQUEEZE;
        end else begin
          step_nxt = step_r + CW'(1);
        end
      end

      ST_SQUEEZE: begin
        // Each cycle closes the lowest gap in the chain.
        chain_op = CH_SQUEEZE;
        if (step_r == CW'(MAX_HOURS - 1)) begin
          step_nxt  = '0;
          state_nxt = ST_ADD;
        end else begin
          step_nxt = step_r + CW'(1);
        end
      end

      ST_ADD: begin
        // Add the counts to the newest bucket and to the totals.
        chain_op         = CH_LOAD_HEAD;
        push_bucket      = head;
        push_bucket.recv = head.recv + rb_r;
        push_bucket.sent = head.sent + sb_r;
        tot_recv_nxt     = tot_recv_r + rb_r;
        tot_sent_nxt     = tot_sent_r + sb_r;
        state_nxt        = ST_IDLE;
      end

      ST_DETAIL: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_last  = (step_r == w_eff - CW'(1));
          if (match) begin
            ld_recv  = head.recv;
            ld_sent  = head.sent;
            chain_op = CH_ROTATE;
            rot_nxt  = rot_r + CW'(1);
          end
          if (hour_r == '0) begin
            neg_nxt = 1'b1;
          end
          hour_nxt = hour_r - HOUR_W'(1);
          if (ld_last) begin
            state_nxt = ST_RESTORE;
          end else begin
            step_nxt = step_r + CW'(1);
          end
        end
      end

      ST_RESTORE: begin
        // Rotate the chain back to its home position.
        if (rot_r == CW'(MAX_HOURS)) begin
          state_nxt = ST_IDLE;
        end else begin
          chain_op = CH_ROTATE;
          rot_nxt  = rot_r + CW'(1);
        end
      end

      ST_TOTAL: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_total  = tot_recv_r + tot_sent_r;
          ld_kept   = KEPT_W'(kept_r);
          ld_last   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      rot_r      <= '0;
      kept_r     <= '0;
      tot_recv_r <= '0;
      tot_sent_r <= '0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      rot_r      <= rot_nxt;
      kept_r     <= kept_nxt;
      tot_recv_r <= tot_recv_nxt;
      tot_sent_r <= tot_sent_nxt;
    end
  end

  // Request payload held for the duration of the request.
  always_ff @(posedge clk) begin
    hour_r <= hour_nxt;
    neg_r  <= neg_nxt;
    rb_r   <= rb_nxt;
    sb_r   <= sb_nxt;
  end

  // Output register between the sequencer and the result channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_recv_r  <= ld_recv;
      out_sent_r  <= ld_sent;
      out_total_r <= ld_total;
      out_kept_r  <= ld_kept;
      out_last_r  <= ld_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hour_recv    = out_recv_r;
  assign out_hour_sent    = out_sent_r;
  assign out_window_total = out_total_r;
  assign out_kept_hours   = out_kept_r;
  assign out_last         = out_last_r;

  // The head bucket is valid exactly when buckets are kept, between requests.
  a_head_matches_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (head.valid == (kept_r != '0)))
    else $error("head bucket validity disagrees with kept count");

  // A result that is not the last one can only come from a detail walk.
  a_non_last_in_detail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_DETAIL))
    else $error("non-final result outside a detail read");

  // The kept count never exceeds the chain length.
  a_kept_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    kept_r <= CW'(MAX_HOURS))
    else $error("kept count exceeds number of cells");

  // The detail walk never rotates further than the hours it has reported so far.
  a_rot_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DETAIL) |-> (rot_r <= step_r))
    else $error("detail walk advanced past the reported hours");

endmodule

// ----- rtl/hwm_cell.sv -----
module hwm_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  hwm_pkg::cell_cmd_t cmd,
  input  hwm_pkg::bucket_t   lo_in,
  input  hwm_pkg::bucket_t   hi_in,
  input  logic               hole_in,
  output hwm_pkg::bucket_t   q,
  output logic               hole_out
);
  import hwm_pkg::*;

  bucket_t bucket_r;
  bucket_t bucket_nxt;

  // A hole at or below this cell means the cell takes its upper neighbour
  // when the chain is squeezed.
  assign hole_out = hole_in | ~bucket_r.valid;
  assign q        = bucket_r;

  // Select the next content of the cell.
  always_comb begin
    unique case (cmd)
      CELL_HOLD:    bucket_nxt = bucket_r;
      CELL_FROM_LO: bucket_nxt = lo_in;
      CELL_FROM_HI: bucket_nxt = hi_in;
      CELL_SQUEEZE: bucket_nxt = hole_out ? hi_in : bucket_r;
      default:      bucket_nxt = bucket_r;
    endcase
  end

  // Only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_r.valid <= 1'b0;
    end else begin
      bucket_r <= bucket_nxt;
    end
  end

endmodule

// ----- rtl/hwm_chain.sv -----
module hwm_chain #(
  parameter int MAX_HOURS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hwm_pkg::chain_op_t op,
  input  hwm_pkg::bucket_t   push_in,
  input  hwm_pkg::bucket_t   wrap_in,
  output hwm_pkg::bucket_t   head
);
  import hwm_pkg::*;

  bucket_t q_a    [MAX_HOURS];
  logic    hole_a [MAX_HOURS];
  bucket_t top_in;

  // The top cell takes the wrapped head when rotating and an empty bucket
  // when squeezing.
  always_comb begin
    top_in = '0;
    if (op == CH_ROTATE) begin
      top_in = wrap_in;
    end
  end

  assign head = q_a[0];

  for (genvar i = 0; i < MAX_HOURS; i++) begin : g_cell
    bucket_t   lo_b;
    bucket_t   hi_b;
    logic      hole_b;
    cell_cmd_t cmd_b;

    // Neighbour wiring at the two ends of the chain.
    if (i == 0) begin : g_first
      assign lo_b   = push_in;
      assign hole_b = 1'b0;
    end else begin : g_inner_lo
      assign lo_b   = q_a[i-1];
      assign hole_b = hole_a[i-1];
    end

    if (i == MAX_HOURS - 1) begin : g_last
      assign hi_b = top_in;
    end else begin : g_inner_hi
      assign hi_b = q_a[i+1];
    end

    // Translate the chain operation into this cell's command.
    always_comb begin
      unique case (op)
        CH_HOLD:      cmd_b = CELL_HOLD;
        CH_PUSH:      cmd_b = CELL_FROM_LO;
        CH_LOAD_HEAD: cmd_b = (i == 0) ? CELL_FROM_LO : CELL_HOLD;
        CH_ROTATE:    cmd_b = CELL_FROM_HI;
        CH_SQUEEZE:   cmd_b = CELL_SQUEEZE;
        default:      cmd_b = CELL_HOLD;
      endcase
    end

    hwm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd_b),
      .lo_in    (lo_b),
      .hi_in    (hi_b),
      .hole_in  (hole_b),
      .q        (q_a[i]),
      .hole_out (hole_a[i])
    );
  end

endmodule

// ----- tb/hourly_traffic_window_meter_test.sv -----
module hourly_traffic_window_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hwm_pkg::*;

  localparam int HOURS = 24;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] ALL_ONES = '1;
  // Longest quiet spell of the block: an add that opens a new hour.
  localparam int SETTLE_CYCLES = 2 * HOURS + 16;
  localparam int PHASE_REQUESTS = 52;
  localparam int PHASES = 8;

  // One result as it leaves the block.
  typedef struct packed {
    logic [BYTE_W-1:0] recv;
    logic [BYTE_W-1:0] sent;
    logic [BYTE_W-1:0] total;
    logic [KEPT_W-1:0] kept;
    logic              last;
  } reading_t;

  // One request, with its result typed in where pinned is set.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [HOUR_W-1:0] hour;
    logic [BYTE_W-1:0] recv;
    logic [BYTE_W-1:0] sent;
    logic              pinned;
    logic [BYTE_W-1:0] pin_total;
    logic [KEPT_W-1:0] pin_kept;
  } probe_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [WIN_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [MODE_W-1:0] in_mode = '0;
  logic [HOUR_W-1:0] in_hour = '0;
  logic [BYTE_W-1:0] in_recv_bytes = '0;
  logic [BYTE_W-1:0] in_sent_bytes = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_hour_recv;
  logic [BYTE_W-1:0] out_hour_sent;
  logic [BYTE_W-1:0] out_window_total;
  logic [KEPT_W-1:0] out_kept_hours;
  logic              out_last;

  // Shadow copy of the bucket store and the window register.
  logic [HOUR_W-1:0] slot_hour [HOURS];
  logic [BYTE_W-1:0] slot_recv [HOURS];
  logic [BYTE_W-1:0] slot_sent [HOURS];
  int                slot_count = 0;
  logic [BYTE_W-1:0] sum_recv = '0;
  logic [BYTE_W-1:0] sum_sent = '0;
  logic [WIN_W-1:0]  window_reg = 5'd24;

  reading_t          due_readings [$];
  reading_t          fresh_readings [$];
  reading_t          seen_reading;
  reading_t          due_reading;

  int                send_idle_pct = 25;
  int                recv_idle_pct = 78;
  int                mismatch_count = 0;
  int                readings_checked = 0;
  int                requests_taken = 0;
  int                windows_written = 0;
  logic [HOUR_W-1:0] clock_hour = '0;

  logic [WIN_W-1:0]  window_plan [PHASES] = '{5'd31, 5'd3, 5'd0, 5'd17, 5'd1, 5'd24, 5'd8,
                                               5'd12};

  probe_t opening_probes [22] = '{
    // Fresh from reset nothing is kept and every hour reads zero.
    '{MODE_TOTAL,  32'd0,         64'd0,    64'd0,    1'b1, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'd0,         64'd0,    64'd0,    1'b1, 64'd0, 5'd0},
    // The unused mode and an empty add leave the store alone.
    '{MODE_UNUSED, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES, 1'b0, 64'd0, 5'd0},
    '{MODE_ADD,    32'd5,         64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    '{MODE_TOTAL,  32'd5,         64'd0,    64'd0,    1'b1, 64'd0, 5'd0},
    // The largest counts wrap the total round to zero.
    '{MODE_ADD,    32'd100,       ALL_ONES, 64'd1,    1'b0, 64'd0, 5'd0},
    '{MODE_TOTAL,  32'd100,       64'd0,    64'd0,    1'b1, 64'd0, 5'd1},
    '{MODE_ADD,    32'd100,       64'd1,    ALL_ONES, 1'b0, 64'd0, 5'd0},
    '{MODE_ADD,    32'd101,       64'd5,    64'd7,    1'b0, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'd101,       64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    // The newest bucket lies past the hour asked for, so every hour reads zero.
    '{MODE_DETAIL, 32'd99,        64'd0,    64'd0,    1'b1, 64'd0, 5'd0},
    // Stepping back drops the later bucket and leaves hour 100 twice.
    '{MODE_ADD,    32'd100,       64'd2,    64'd3,    1'b0, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'd100,       64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    '{MODE_TOTAL,  32'd100,       64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    // The top of the hour range purges everything, then one hour back.
    '{MODE_ADD,    32'hFFFF_FFFF, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
      1'b0, 64'd0, 5'd0},
    '{MODE_ADD,    32'hFFFF_FFFE, 64'h2AAA_AAAA_AAAA_AAAA, 64'd0, 1'b0, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'hFFFF_FFFF, 64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    '{MODE_TOTAL,  32'd0,         64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    // At hour zero the read walks below the first hour.
    '{MODE_ADD,    32'd0,         64'd0,    64'd9,    1'b0, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'd0,         64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    '{MODE_DETAIL, 32'hFFFF_FFFF, 64'd0,    64'd0,    1'b0, 64'd0, 5'd0},
    '{MODE_TOTAL,  32'd0,         64'd0,    64'd0,    1'b0, 64'd0, 5'd0}
  };

  hourly_traffic_window_meter #(.MAX_HOURS(HOURS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_hour          (in_hour),
    .in_recv_bytes    (in_recv_bytes),
    .in_sent_bytes    (in_sent_bytes),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hour_recv    (out_hour_recv),
    .out_hour_sent    (out_hour_sent),
    .out_window_total (out_window_total),
    .out_kept_hours   (out_kept_hours),
    .out_last         (out_last)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The window in force, clamped to the size of the store.
  function automatic int span_hours();
    if (window_reg < 1) return 1;
    if (window_reg > HOURS) return HOURS;
    return int'(window_reg);
  endfunction

  // Works out what one accepted request does to the store and what it returns.
  function automatic void meter_forecast(input logic [MODE_W-1:0] md,
                                         input logic [HOUR_W-1:0] hr,
                                         input logic [BYTE_W-1:0] rb,
                                         input logic [BYTE_W-1:0] sb);
    int       n;
    int       i;
    int       dst;
    int       p;
    int       w;
    longint   top;
    longint   floor_lim;
    longint   h;
    longint   bh;
    reading_t r;
    fresh_readings.delete();
    case (md)
      MODE_ADD: begin
        if (rb != '0 || sb != '0) begin
          // A new hour opens a bucket at the head, then the window is purged.
          if (slot_count == 0 || slot_hour[0] != hr) begin
            n = (slot_count >= HOURS) ? HOURS - 1 : slot_count;
            for (i = n; i > 0; i--) begin
              slot_hour[i] = slot_hour[i-1];
              slot_recv[i] = slot_recv[i-1];
              slot_sent[i] = slot_sent[i-1];
            end
            slot_hour[0] = hr;
            slot_recv[0] = '0;
            slot_sent[0] = '0;
            slot_count = n + 1;
            top = {32'b0, hr};
            floor_lim = top - span_hours();
            sum_recv = '0;
            sum_sent = '0;
            dst = 0;
            for (i = 0; i < slot_count; i++) begin
              h = {32'b0, slot_hour[i]};
              if (h > floor_lim && h <= top) begin
                slot_hour[dst] = slot_hour[i];
                slot_recv[dst] = slot_recv[i];
                slot_sent[dst] = slot_sent[i];
                sum_recv += slot_recv[i];
                sum_sent += slot_sent[i];
                dst++;
              end
            end
            slot_count = dst;
          end
          slot_recv[0] += rb;
          slot_sent[0] += sb;
          sum_recv += rb;
          sum_sent += sb;
        end
      end
      MODE_DETAIL: begin
        // Walk back hour by hour; a bucket is used once, on its first match.
        w = span_hours();
        h = {32'b0, hr};
        p = 0;
        for (i = 0; i < w; i++) begin
          r = '0;
          if (p < slot_count && h >= 0) begin
            bh = {32'b0, slot_hour[p]};
            if (bh == h) begin
              r.recv = slot_recv[p];
              r.sent = slot_sent[p];
              p++;
            end
          end
          r.last = (i == w - 1);
          fresh_readings.push_back(r);
          h--;
        end
      end
      MODE_TOTAL: begin
        r = '0;
        r.total = sum_recv + sum_sent;
        r.kept = KEPT_W'(slot_count);
        r.last = 1'b1;
        fresh_readings.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] pick_count();
    case ($urandom_range(7))
      0: return ALL_ONES;
      1, 2: return {$urandom, $urandom};
      3: return BYTE_W'(1) << $urandom_range(63);
      default: return BYTE_W'($urandom_range(5000));
    endcase
  endfunction

  function automatic logic [HOUR_W-1:0] far_hour();
    case ($urandom_range(3))
      0: return HOUR_W'($urandom_range(30));
      1: return {HOUR_W{1'b1}} - HOUR_W'($urandom_range(40));
      default: return $urandom;
    endcase
  endfunction

  // Offers one request, waits for it to be taken and books its results.
  task automatic send_request(input probe_t rq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= rq.mode;
    in_hour <= rq.hour;
    in_recv_bytes <= rq.recv;
    in_sent_bytes <= rq.sent;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    meter_forecast(rq.mode, rq.hour, rq.recv, rq.sent);
    foreach (fresh_readings[k]) begin
      if (rq.pinned) begin
        fresh_readings[k].recv = '0;
        fresh_readings[k].sent = '0;
        fresh_readings[k].total = rq.pin_total;
        fresh_readings[k].kept = rq.pin_kept;
      end
      due_readings.push_back(fresh_readings[k]);
    end
    requests_taken++;
    @(negedge clk);
  endtask

  // The window register is only written once the block has gone quiet.
  task automatic set_window(input logic [WIN_W-1:0] value);
    while (due_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    window_reg = value;
    windows_written++;
  endtask

  // A run of 20 to 27 consecutive hours, which can fill the store and push out the oldest.
  task automatic sweep_hours(inout int work);
    probe_t rq;
    int     n;
    int     i;
    n = $urandom_range(20, 27);
    for (i = 0; i < n; i++) begin
      clock_hour += 1;
      rq = '0;
      rq.mode = MODE_ADD;
      rq.hour = clock_hour;
      rq.recv = pick_count();
      rq.sent = pick_count() | BYTE_W'(1);
      send_request(rq);
      work++;
      if ($urandom_range(5) == 0) begin
        rq.mode = MODE_DETAIL;
        send_request(rq);
        work++;
      end
    end
  endtask

  // Mostly traffic near the current hour with reads around it, some noise.
  task automatic random_request(inout int work);
    probe_t      rq;
    int unsigned roll;
    rq = '0;
    roll = $urandom_range(99);
    if ($urandom_range(39) == 0) clock_hour = far_hour();
    rq.recv = pick_count();
    rq.sent = pick_count();
    if (roll < 50) begin
      rq.mode = MODE_ADD;
      case ($urandom_range(9))
        0: clock_hour -= HOUR_W'($urandom_range(3));
        1, 2, 3: clock_hour += 1;
        4: clock_hour += HOUR_W'($urandom_range(30));
        default: ;
      endcase
      rq.hour = clock_hour;
      case ($urandom_range(19))
        0: begin
          rq.recv = '0;
          rq.sent = '0;
        end
        1, 2: rq.recv = '0;
        3, 4: rq.sent = '0;
        default: ;
      endcase
    end else if (roll < 80) begin
      rq.mode = MODE_DETAIL;
      if ($urandom_range(9) == 0) begin
        rq.hour = $urandom;
      end else begin
        rq.hour = clock_hour + HOUR_W'($urandom_range(2)) - HOUR_W'($urandom_range(4));
      end
    end else if (roll < 95) begin
      rq.mode = MODE_TOTAL;
      rq.hour = $urandom;
    end else begin
      rq.mode = MODE_UNUSED;
      rq.hour = $urandom;
    end
    send_request(rq);
    if (rq.mode != MODE_UNUSED && !(rq.mode == MODE_ADD && rq.recv == '0 && rq.sent == '0)) begin
      work++;
    end
  endtask

  // The result side stalls at random, as the current profile sets.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Each result taken is checked against the oldest one booked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_reading = {out_hour_recv, out_hour_sent, out_window_total, out_kept_hours, out_last};
      if (due_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result with none due: recv %h sent %h total %h kept %0d last %b",
                   $realtime, seen_reading.recv, seen_reading.sent, seen_reading.total,
                   seen_reading.kept, seen_reading.last);
        end
      end else begin
        due_reading = due_readings.pop_front();
        readings_checked++;
        if (seen_reading.recv !== due_reading.recv || seen_reading.sent !== due_reading.sent ||
            seen_reading.total !== due_reading.total || seen_reading.kept !== due_reading.kept ||
            seen_reading.last !== due_reading.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: expected recv %h sent %h total %h kept %0d last %b", $realtime,
                     due_reading.recv, due_reading.sent, due_reading.total, due_reading.kept,
                     due_reading.last);
            $display("%0t: actual   recv %h sent %h total %h kept %0d last %b", $realtime,
                     seen_reading.recv, seen_reading.sent, seen_reading.total,
                     seen_reading.kept, seen_reading.last);
          end
        end
      end
    end
  end

  initial begin
    int work;
    int phase;
    clock_hour = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests at the reset window.
    foreach (opening_probes[i]) send_request(opening_probes[i]);
    in_valid <= 1'b0;

    // Random phases, each under a new window setting; the idling profile changes at phases 3 and 6.
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 78;
        recv_idle_pct = 25;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_window(window_plan[phase]);
      work = 0;
      sweep_hours(work);
      while (work < PHASE_REQUESTS) random_request(work);
      in_valid <= 1'b0;
    end

    while (due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d requests under %0d window settings; %0d results compared.",
             requests_taken, windows_written + 1, readings_checked);
    $display("Mismatches or unexpected results: %0d.", mismatch_count);
    if (mismatch_count == 0 && due_readings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/hwm_pkg.sv
rtl/hwm_cell.sv
rtl/hwm_chain.sv
rtl/hourly_traffic_window_meter.sv
tb/hourly_traffic_window_meter_test.sv
